### rtl/ilid_pkg.sv
// ilid_pkg: shared types, codes and sizes for the indexed list core
// holds beat structs, command and status codes, and the cell control word
// no dependencies
package ilid_pkg;

	localparam int CAPACITY   = 16;
	localparam int ITEM_WIDTH = 32;

	// fixed field widths of the beats
	localparam int CMD_W  = 3;
	localparam int POS_W  = 4;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int CNTF_W = 5;

	// count register holds 0..CAPACITY, compares run at the wider of count and position
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FETCH  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] item_word;
	} req_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_word;
		logic [STAT_W-1:0] status;
		logic [CNTF_W-1:0] count_now;
	} rsp_beat_t;

	// what every cell does this cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_INSERT,
		OP_DELETE,
		OP_FETCH,
		OP_CLEAR
	} cell_op_t;

	// control word broadcast along the row of cells
	typedef struct packed {
		cell_op_t              op;
		logic [CMP_W-1:0]      pos;
		logic [CMP_W-1:0]      cnt;
		logic [ITEM_WIDTH-1:0] item;
	} cell_ctl_t;

	// per-command outcome from the decoder
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count_next;
	} ctl_res_t;

endpackage

### rtl/ilid_cell.sv
// ilid_cell: one slot of the list, shifts to or from its neighbors
// depends on ilid_pkg
module ilid_cell import ilid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CMP_W-1:0]      idx,
	input  cell_ctl_t             ctl,
	input  logic [ITEM_WIDTH-1:0] left,
	input  logic [ITEM_WIDTH-1:0] right,
	output logic [ITEM_WIDTH-1:0] slot,
	output logic [ITEM_WIDTH-1:0] rd
);

	logic [ITEM_WIDTH-1:0] slot_q;
	logic [ITEM_WIDTH-1:0] slot_d;
	logic [CMP_W-1:0]      idx_inc;
	logic                  at_pos;

	assign idx_inc = idx + CMP_W'(1);
	assign at_pos  = (idx == ctl.pos);

	always_comb begin
		slot_d = slot_q;
		case (ctl.op)
			OP_WRITE: begin
				if (at_pos) slot_d = ctl.item;
			end
			OP_INSERT: begin
				if (at_pos) slot_d = ctl.item;
				else if (idx > ctl.pos && idx <= ctl.cnt) slot_d = left;
			end
			OP_DELETE: begin
				// top live slot falls free and is zeroed
				if (idx >= ctl.pos && idx_inc < ctl.cnt) slot_d = right;
				else if (idx >= ctl.pos && idx_inc == ctl.cnt) slot_d = '0;
			end
			OP_CLEAR: slot_d = '0;
			default: slot_d = slot_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

	assign slot = slot_q;
	assign rd   = (ctl.op == OP_FETCH && at_pos) ? slot_q : '0;

endmodule

### rtl/ilid_ctrl.sv
// ilid_ctrl: decodes a command beat against the live count
// depends on ilid_pkg; drives the cell control word and the result status
module ilid_ctrl import ilid_pkg::*; (
	input  logic             fire,
	input  req_beat_t        req,
	input  logic [CNT_W-1:0] count,
	output cell_ctl_t        ctl,
	output ctl_res_t         res
);

	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	cell_op_t         op;

	assign cnt_x = CMP_W'(count);
	assign pos_x = CMP_W'(req.position);

	always_comb begin
		op             = OP_NONE;
		ctl.pos        = pos_x;
		ctl.cnt        = cnt_x;
		ctl.item       = ITEM_WIDTH'(req.item_word);
		res.status     = ST_OK;
		res.count_next = count;
		case (req.cmd)
			CMD_PUSH: begin
				if (cnt_x >= CAP_C) begin
					res.status = ST_FULL;
				end else begin
					op             = OP_WRITE;
					ctl.pos        = cnt_x;
					res.count_next = count + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (pos_x > cnt_x) begin
					res.status = ST_RANGE;
				end else if (cnt_x >= CAP_C) begin
					res.status = ST_FULL;
				end else begin
					op             = OP_INSERT;
					res.count_next = count + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (pos_x >= cnt_x) begin
					res.status = ST_RANGE;
				end else begin
					op             = OP_DELETE;
					res.count_next = count - CNT_W'(1);
				end
			end
			CMD_FETCH: begin
				if (pos_x >= cnt_x) res.status = ST_RANGE;
				else op = OP_FETCH;
			end
			CMD_CHANGE: begin
				if (pos_x >= cnt_x) res.status = ST_RANGE;
				else op = OP_WRITE;
			end
			CMD_SET: begin
				if (pos_x >= CAP_C) res.status = ST_RANGE;
				else op = OP_WRITE;
			end
			CMD_CLEAR: begin
				op             = OP_CLEAR;
				res.count_next = '0;
			end
			default: op = OP_NONE;
		endcase
		ctl.op = fire ? op : OP_NONE;
	end

endmodule

### rtl/indexed_list_insert_delete_core.sv
// indexed_list_insert_delete_core: bounded ordered list in a row of shift cells
// depends on ilid_pkg, ilid_ctrl and ilid_cell
//
// the list lives in CAPACITY identical cells, one slot each, plus a live count
// register. a command beat is decoded against the count and broadcast to every
// cell; insert moves each slot above the position up one cell and delete moves
// them down one cell, all in the same clock edge, so every command (push,
// insert, delete, fetch, change, set, clear) completes at that edge and a new
// command beat can be taken every unstalled cycle. the result beat (read word,
// status, count after the command) sits in an output register the cycle after
// the command is taken; the command side stalls only while that register holds
// a beat the consumer is stalling. fetch reads through an or-combine of the cells.
// errors (position out of range, list full) leave slots and count untouched.
module indexed_list_insert_delete_core import ilid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	// handshake and result register
	logic             fire;
	logic             rsp_valid_q;
	rsp_beat_t        rsp_q;

	// live entry count
	logic [CNT_W-1:0] count_q;

	// decoder outputs
	cell_ctl_t        ctl;
	ctl_res_t         res;

	// row of cells
	logic [ITEM_WIDTH-1:0] cell_slot [CAPACITY];
	logic [ITEM_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [ITEM_WIDTH-1:0] rd_any;

	// take a command whenever the result register is free or being drained
	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;

	ilid_ctrl u_ctrl (
		.fire  (fire),
		.req   (req),
		.count (count_q),
		.ctl   (ctl),
		.res   (res)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left_w;
		logic [ITEM_WIDTH-1:0] right_w;

		// edge cells see zero beyond the row
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_slot[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_slot[i+1];
		end

		ilid_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (CMP_W'(i)),
			.ctl    (ctl),
			.left   (left_w),
			.right  (right_w),
			.slot   (cell_slot[i]),
			.rd     (cell_rd[i])
		);
	end

	// only the addressed cell drives a nonzero fetch word
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= res.count_next;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.read_word <= WORD_W'(rd_any);
			rsp_q.status    <= res.status;
			rsp_q.count_now <= CNTF_W'(res.count_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("live count above capacity");

	// every taken command yields a result beat next cycle
	a_fire_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("command taken without result beat");

	// full status only reported with a full list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ST_FULL |-> rsp_q.count_now == CNTF_W'(CAPACITY))
		else $error("full status with room left");

	// a nonzero read word only comes with ok status
	a_rd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.read_word != '0 |-> rsp_q.status == ST_OK)
		else $error("read word on error result");

	// clear empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.cmd == CMD_CLEAR |=> count_q == '0)
		else $error("clear left entries");

endmodule
